// ----- design/text_console_char_buffer_unit_assert.svh -----
// Assertion macros for the text console char buffer checker.
// Included by the checker file; needs nothing else.
`ifndef TEXT_CONSOLE_CHAR_BUFFER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TCCB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tccb_pkg.sv -----
// Shared types and constants for the text console char buffer.
// No dependencies; used by tccb_cursor, the top level and the checker.
package tccb_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int TAB_STOP = 8;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int TAB_W  = $clog2(TAB_STOP);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int CHAR_W = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

  localparam logic [COL_W:0] COLS_RESET = (COL_W+1)'(80);
  localparam logic [ROW_W:0] ROWS_RESET = (ROW_W+1)'(25);
  localparam logic [COL_W:0] COLS_MIN   = (COL_W+1)'(8);
  localparam logic [COL_W:0] COLS_MAX   = (COL_W+1)'(MAX_COLS);
  localparam logic [ROW_W:0] ROWS_MAX   = (ROW_W+1)'(MAX_ROWS);

  localparam logic [1:0] KIND_PUT    = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        char_code;
    logic signed [7:0] scroll_lines;
    logic [5:0]        read_row;
    logic [6:0]        read_col;
  } req_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [6:0] cursor_col;
    logic [5:0] cursor_row;
    logic       lines_advanced;
  } rsp_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [COL_W:0]    cols;
    logic [ROW_W:0]    rows;
    logic [CHAR_W-1:0] char_code;
  } put_in_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             adv;
    logic             write_cell;
    logic             overflow;
  } put_out_t;

endpackage

// ----- design/tccb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tccb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/tccb_cursor.sv -----
// Cursor move for one put request: control codes, tab, wrap, row overflow.
// Depends on tccb_pkg.
module tccb_cursor (
  input  tccb_pkg::put_in_t  pin,
  output tccb_pkg::put_out_t pout
);

  logic [tccb_pkg::COL_W:0] col_n;
  logic [tccb_pkg::ROW_W:0] row_n;
  logic                     adv;
  logic                     wr;
  logic                     over;

  always_comb begin
    col_n = {1'b0, pin.col};
    row_n = {1'b0, pin.row};
    adv   = 1'b0;
    wr    = 1'b0;
    over  = 1'b0;
    case (pin.char_code)
      tccb_pkg::CH_NUL: begin
        col_n = {1'b0, pin.col};
      end
      tccb_pkg::CH_CR: begin
        col_n = '0;
      end
      tccb_pkg::CH_LF: begin
        col_n = '0;
        row_n = row_n + 1'b1;
        adv   = 1'b1;
      end
      tccb_pkg::CH_FF: begin
        row_n = row_n + 1'b1;
        adv   = 1'b1;
      end
      tccb_pkg::CH_TAB: begin
        col_n = ((col_n >> tccb_pkg::TAB_W) + (tccb_pkg::COL_W+1)'(1)) << tccb_pkg::TAB_W;
      end
      default: begin
        wr    = 1'b1;
        col_n = col_n + 1'b1;
      end
    endcase
    // cursor is always inside the active area, so at most one wrap
    if (col_n >= pin.cols) begin
      col_n = col_n - pin.cols;
      row_n = row_n + 1'b1;
      adv   = 1'b1;
    end
    // at most one row past the end: scroll by one
    if (row_n >= pin.rows) begin
      over  = 1'b1;
      row_n = pin.rows - 1'b1;
    end
  end

  assign pout.col        = col_n[tccb_pkg::COL_W-1:0];
  assign pout.row        = row_n[tccb_pkg::ROW_W-1:0];
  assign pout.adv        = adv;
  assign pout.write_cell = wr;
  assign pout.overflow   = over;

endmodule

// ----- design/text_console_char_buffer_unit.sv -----
// Text console char buffer, top level: cell RAM, cursor, scroll/clear sweep engine.
// Put (no overflow), read and empty scroll: accept -> ST_RESULT -> response register, held by rsp_stall.
//   Scroll or overflowing put: sweep of 128 cells per active row; clear: all 8192 cells; one cell per cycle.
// Requests: one at a time; the next is taken once the result is loaded and the last sweep write has landed.
// Reset: sync, active high; a clearing pass writes spaces, with req_stall high until its last write lands.
// Depends on tccb_pkg, tccb_ram, tccb_cursor.
module text_console_char_buffer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  tccb_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output tccb_pkg::rsp_t                    rsp,
  input  logic                              cfg_we,
  input  logic [tccb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tccb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Control: idle waits for a request, sweep moves/blanks one cell per
  // cycle through the RAM, result loads the output register.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SWEEP  = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  // Sweep kinds: rows move up, rows move down, or the whole store blanks.
  typedef enum logic [1:0] {
    SW_UP,
    SW_DOWN,
    SW_FILL
  } sweep_mode_t;

  state_t state;

  // Active area, kept saturated to its legal range.
  logic [tccb_pkg::COL_W:0]   cols;
  logic [tccb_pkg::COL_W:0]   cols_next;
  logic [tccb_pkg::ROW_W:0]   rows;
  logic [tccb_pkg::ROW_W:0]   rows_next;
  logic [tccb_pkg::ROW_W:0]   rows_cfg;

  logic [tccb_pkg::COL_W-1:0] cur_col;
  logic [tccb_pkg::ROW_W-1:0] cur_row;

  // Sweep engine: destination row/col counters and the row distance.
  sweep_mode_t                sw_mode;
  logic [tccb_pkg::ROW_W:0]   sw_n;
  logic [tccb_pkg::ROW_W-1:0] sw_row;
  logic [tccb_pkg::COL_W-1:0] sw_col;
  logic                       sw_to_idle;
  logic                       sw_copy;
  logic [tccb_pkg::ROW_W-1:0] src_row;
  logic                       col_last;
  logic                       row_last;

  // Write stage of the sweep: data read last cycle lands here.
  logic                        p_valid;
  logic                        p_copy;
  logic [tccb_pkg::ADDR_W-1:0] p_addr;

  logic res_read;
  logic res_adv;

  logic accept;
  logic [7:0]                 scroll_mag;
  logic [tccb_pkg::ROW_W:0]   scroll_n;

  tccb_pkg::put_in_t  pin;
  tccb_pkg::put_out_t pout;

  logic                        ram_we;
  logic [tccb_pkg::ADDR_W-1:0] ram_waddr;
  logic [tccb_pkg::CHAR_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [tccb_pkg::ADDR_W-1:0] ram_raddr;
  logic [tccb_pkg::CHAR_W-1:0] ram_rdata;

  // The last sweep write lands in the cycle after the sweep ends; after the reset
  // pass that cycle is already idle, so hold requests off until it is done.
  assign req_stall = (state != ST_IDLE) || p_valid;
  assign accept    = req_valid && !req_stall;

  // Register writes: columns saturate to 8..MAX_COLS; rows take the low ROW_W+1 data bits, saturated to 1..MAX_ROWS.
  assign rows_cfg = cfg_data[tccb_pkg::ROW_W:0];

  always_comb begin
    cols_next = cols;
    rows_next = rows;
    if (cfg_we) begin
      case (cfg_index)
        tccb_pkg::CFG_COLS: begin
          if (cfg_data < tccb_pkg::COLS_MIN) begin
            cols_next = tccb_pkg::COLS_MIN;
          end else if (cfg_data > tccb_pkg::COLS_MAX) begin
            cols_next = tccb_pkg::COLS_MAX;
          end else begin
            cols_next = cfg_data;
          end
        end
        tccb_pkg::CFG_ROWS: begin
          if (rows_cfg == '0) begin
            rows_next = (tccb_pkg::ROW_W+1)'(1);
          end else if (rows_cfg > tccb_pkg::ROWS_MAX) begin
            rows_next = tccb_pkg::ROWS_MAX;
          end else begin
            rows_next = rows_cfg;
          end
        end
        default: begin
          cols_next = cols;
        end
      endcase
    end
  end

  // Scroll count magnitude, clamped to the rows in use.
  assign scroll_mag = req.scroll_lines[7] ? $unsigned(-req.scroll_lines)
                                          : $unsigned(req.scroll_lines);
  assign scroll_n   = (scroll_mag > {1'b0, rows}) ? rows
                                                  : scroll_mag[tccb_pkg::ROW_W:0];

  // Cursor arithmetic for put requests.
  assign pin.col       = cur_col;
  assign pin.row       = cur_row;
  assign pin.cols      = cols;
  assign pin.rows      = rows;
  assign pin.char_code = req.char_code;

  tccb_cursor u_cursor (
    .pin  (pin),
    .pout (pout)
  );

  // Sweep addressing. Up: destination rows ascend and copy from row+n until
  // the source runs out, then blank. Down: destination rows descend and copy
  // from row-n while it exists, then blank. Reads always run ahead of the
  // writes that could hit them, so no forwarding is needed.
  always_comb begin
    case (sw_mode)
      SW_UP: begin
        sw_copy  = ({2'b00, sw_row} + {1'b0, sw_n}) < {1'b0, rows};
        src_row  = sw_row + sw_n[tccb_pkg::ROW_W-1:0];
        row_last = ({1'b0, sw_row} == (rows - 1'b1));
      end
      SW_DOWN: begin
        sw_copy  = ({1'b0, sw_row} >= sw_n);
        src_row  = sw_row - sw_n[tccb_pkg::ROW_W-1:0];
        row_last = (sw_row == '0);
      end
      default: begin
        sw_copy  = 1'b0;
        src_row  = sw_row;
        row_last = (sw_row == tccb_pkg::ROW_W'(tccb_pkg::MAX_ROWS - 1));
      end
    endcase
  end

  assign col_last = (sw_col == tccb_pkg::COL_W'(tccb_pkg::MAX_COLS - 1));

  // RAM ports. The sweep write stage and the put write never overlap:
  // no request is taken while the write stage is busy.
  assign ram_we    = p_valid
                     || (accept && (req.kind == tccb_pkg::KIND_PUT) && pout.write_cell);
  assign ram_waddr = p_valid ? p_addr : {cur_row, cur_col};
  assign ram_wdata = p_valid ? (p_copy ? ram_rdata : tccb_pkg::CH_BLANK) : req.char_code;
  assign ram_re    = ((state == ST_SWEEP) && sw_copy)
                     || (accept && (req.kind == tccb_pkg::KIND_READ));
  assign ram_raddr = (state == ST_SWEEP) ? {src_row, sw_col} : {req.read_row, req.read_col};

  tccb_ram #(
    .WIDTH (tccb_pkg::CHAR_W),
    .DEPTH (tccb_pkg::DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sw_mode    <= SW_FILL;
      sw_row     <= '0;
      sw_col     <= '0;
      sw_n       <= '0;
      sw_to_idle <= 1'b1;
      cols       <= tccb_pkg::COLS_RESET;
      rows       <= tccb_pkg::ROWS_RESET;
      cur_col    <= '0;
      cur_row    <= '0;
      rsp_valid  <= 1'b0;
      p_valid    <= 1'b0;
      res_read   <= 1'b0;
      res_adv    <= 1'b0;
    end else begin
      cols    <= cols_next;
      rows    <= rows_next;
      p_valid <= (state == ST_SWEEP);
      p_copy  <= sw_copy;
      p_addr  <= {sw_row, sw_col};

      // shrinking the area pulls the cursor onto its last column/row
      if (cfg_we) begin
        if ({1'b0, cur_col} >= cols_next) begin
          cur_col <= tccb_pkg::COL_W'(cols_next - 1'b1);
        end
        if ({1'b0, cur_row} >= rows_next) begin
          cur_row <= tccb_pkg::ROW_W'(rows_next - 1'b1);
        end
      end

      // the result state reloads the output register itself
      if (rsp_valid && !rsp_stall && (state != ST_RESULT)) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            sw_col     <= '0;
            sw_to_idle <= 1'b0;
            res_read   <= 1'b0;
            res_adv    <= 1'b0;
            case (req.kind)
              tccb_pkg::KIND_PUT: begin
                cur_col <= pout.col;
                cur_row <= pout.row;
                res_adv <= pout.adv;
                if (pout.overflow) begin
                  sw_mode <= SW_UP;
                  sw_n    <= (tccb_pkg::ROW_W+1)'(1);
                  sw_row  <= '0;
                  state   <= ST_SWEEP;
                end else begin
                  state <= ST_RESULT;
                end
              end
              tccb_pkg::KIND_SCROLL: begin
                if (scroll_n != '0) begin
                  sw_n <= scroll_n;
                  if (req.scroll_lines[7]) begin
                    sw_mode <= SW_DOWN;
                    sw_row  <= tccb_pkg::ROW_W'(rows - 1'b1);
                  end else begin
                    sw_mode <= SW_UP;
                    sw_row  <= '0;
                  end
                  state <= ST_SWEEP;
                end else begin
                  state <= ST_RESULT;
                end
              end
              tccb_pkg::KIND_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
                sw_mode <= SW_FILL;
                sw_row  <= '0;
                state   <= ST_SWEEP;
              end
              default: begin
                res_read <= 1'b1;
                state    <= ST_RESULT;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          sw_col <= sw_col + 1'b1;
          if (col_last) begin
            sw_row <= (sw_mode == SW_DOWN) ? sw_row - 1'b1 : sw_row + 1'b1;
            if (row_last) begin
              state <= sw_to_idle ? ST_IDLE : ST_RESULT;
            end
          end
        end
        ST_RESULT: begin
          // read data stays in the RAM output register until the next read
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid          <= 1'b1;
            rsp.cell_char      <= res_read ? ram_rdata : tccb_pkg::CH_NUL;
            rsp.cursor_col     <= cur_col;
            rsp.cursor_row     <= cur_row;
            rsp.lines_advanced <= res_adv;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/tccb_checker.sv -----
// Port-level checks for text_console_char_buffer_unit, bound to the top level.
// Depends on tccb_pkg and text_console_char_buffer_unit_assert.svh.
`include "text_console_char_buffer_unit_assert.svh"

module tccb_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input tccb_pkg::rsp_t rsp
);

  // a held response keeps its payload
  `TCCB_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response changed while stalled")

  // one request at a time: the cycle after an accept takes nothing
  `TCCB_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && !req_stall, req_stall, "request accepted while another in flight")

  // clearing pass right after reset
  `TCCB_ASSERT_NOW(a_init_busy, clk, rst, $past(rst), req_stall, "request side open during clearing pass")

  // only puts advance lines, only reads carry a cell
  `TCCB_ASSERT_NOW(a_adv_no_cell, clk, rst, rsp_valid && rsp.lines_advanced, rsp.cell_char == 8'h00, "line advance with cell data")

endmodule

bind text_console_char_buffer_unit tccb_checker u_tccb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
